// ----- src/tpbkt_pkg.sv -----
// ----------------------------------------------------------------------------
// tpbkt_pkg
// Shared types and constants of the two-pool blocked keyword table.
// ----------------------------------------------------------------------------
package tpbkt_pkg;

  localparam int unsigned VolatileDepthDef   = 16;
  localparam int unsigned PersistentDepthDef = 16;
  localparam int unsigned IdWidthDef         = 16;

  // fixed widths of the beat fields
  localparam int unsigned KeywordW = 16;
  localparam int unsigned UsedW    = 5;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ALREADY   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FV_RD,
    S_FV_CMP,
    S_FP_RD,
    S_FP_CMP,
    S_DV_RD,
    S_DV_WR,
    S_DP_RD,
    S_DP_WR,
    S_APP_V,
    S_APP_P,
    S_DONE
  } ctrl_state_e;

  // pool: 0 volatile, 1 persistent
  typedef struct packed {
    logic pool;
    logic key_load;
    logic idx_clr;
    logic idx_inc;
    logic rd_en;
    logic rd_next;
    logic wr_en;
    logic app_en;
    logic cnt_dec;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic at_end;
    logic last;
    logic match;
    logic v_full;
    logic p_full;
  } dp_stat_t;

endpackage

// ----- src/tpbkt_ram.sv -----
// ----------------------------------------------------------------------------
// tpbkt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpbkt_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/tpbkt_datapath.sv -----
// ----------------------------------------------------------------------------
// tpbkt_datapath
// Pool RAMs, fill counts, scan index and key register of the keyword table.
// ----------------------------------------------------------------------------
module tpbkt_datapath #(
  parameter int unsigned VolatileDepth   = tpbkt_pkg::VolatileDepthDef,
  parameter int unsigned PersistentDepth = tpbkt_pkg::PersistentDepthDef,
  parameter int unsigned IdWidth         = tpbkt_pkg::IdWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tpbkt_pkg::KeywordW-1:0] keyword_i,
  input  tpbkt_pkg::dp_cmd_t            cmd_i,
  output tpbkt_pkg::dp_stat_t           stat_o,
  output logic [tpbkt_pkg::UsedW-1:0]   volatile_used_o,
  output logic [tpbkt_pkg::UsedW-1:0]   persistent_used_o
);

  localparam int unsigned KeyW = (IdWidth < tpbkt_pkg::KeywordW) ? IdWidth
                                                                 : tpbkt_pkg::KeywordW;
  localparam int unsigned VCntW = $clog2(VolatileDepth + 1);
  localparam int unsigned PCntW = $clog2(PersistentDepth + 1);
  localparam int unsigned IdxW  = (VCntW > PCntW) ? VCntW : PCntW;
  localparam int unsigned VAddrW = (VolatileDepth > 1) ? $clog2(VolatileDepth) : 1;
  localparam int unsigned PAddrW = (PersistentDepth > 1) ? $clog2(PersistentDepth) : 1;

  logic [KeyW-1:0]  key_q;
  logic [VCntW-1:0] v_cnt_q, v_cnt_d;
  logic [PCntW-1:0] p_cnt_q, p_cnt_d;
  logic [IdxW-1:0]  idx_q, idx_d;

  logic [IdxW-1:0]  v_cnt_x, p_cnt_x, cnt_sel;
  logic [IdxW:0]    idx_nxt_w;
  logic [IdxW-1:0]  raddr_full, v_waddr_full, p_waddr_full;
  logic [KeyW-1:0]  v_rdata, p_rdata, rdata_sel, v_wdata, p_wdata;
  logic             v_we, p_we, v_re, p_re;
  logic [31:0]      v_used_x, p_used_x;

  assign v_cnt_x   = IdxW'(v_cnt_q);
  assign p_cnt_x   = IdxW'(p_cnt_q);
  assign cnt_sel   = cmd_i.pool ? p_cnt_x : v_cnt_x;
  assign rdata_sel = cmd_i.pool ? p_rdata : v_rdata;
  assign idx_nxt_w = {1'b0, idx_q} + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_load) begin
      key_q <= keyword_i[KeyW-1:0];
    end
  end

  always_comb begin
    v_cnt_d = v_cnt_q;
    p_cnt_d = p_cnt_q;
    if (cmd_i.clear) begin
      v_cnt_d = '0;
      p_cnt_d = '0;
    end else if (cmd_i.app_en) begin
      if (cmd_i.pool) p_cnt_d = PCntW'(p_cnt_q + 1'b1);
      else            v_cnt_d = VCntW'(v_cnt_q + 1'b1);
    end else if (cmd_i.cnt_dec) begin
      if (cmd_i.pool) p_cnt_d = PCntW'(p_cnt_q - 1'b1);
      else            v_cnt_d = VCntW'(v_cnt_q - 1'b1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_nxt_w[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_cnt_q <= '0;
      p_cnt_q <= '0;
      idx_q   <= '0;
    end else begin
      v_cnt_q <= v_cnt_d;
      p_cnt_q <= p_cnt_d;
      idx_q   <= idx_d;
    end
  end

  // drop reads one slot ahead and writes it back one slot lower
  assign raddr_full   = cmd_i.rd_next ? idx_nxt_w[IdxW-1:0] : idx_q;
  assign v_waddr_full = cmd_i.app_en ? v_cnt_x : idx_q;
  assign p_waddr_full = cmd_i.app_en ? p_cnt_x : idx_q;
  assign v_wdata      = cmd_i.app_en ? key_q : v_rdata;
  assign p_wdata      = cmd_i.app_en ? key_q : p_rdata;
  assign v_we = (cmd_i.wr_en || cmd_i.app_en) && !cmd_i.pool;
  assign p_we = (cmd_i.wr_en || cmd_i.app_en) &&  cmd_i.pool;
  assign v_re = cmd_i.rd_en && !cmd_i.pool;
  assign p_re = cmd_i.rd_en &&  cmd_i.pool;

  tpbkt_ram #(
    .Width (KeyW),
    .Depth (VolatileDepth)
  ) u_v_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr_full[VAddrW-1:0]),
    .wdata_i (v_wdata),
    .re_i    (v_re),
    .raddr_i (raddr_full[VAddrW-1:0]),
    .rdata_o (v_rdata)
  );

  tpbkt_ram #(
    .Width (KeyW),
    .Depth (PersistentDepth)
  ) u_p_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr_full[PAddrW-1:0]),
    .wdata_i (p_wdata),
    .re_i    (p_re),
    .raddr_i (raddr_full[PAddrW-1:0]),
    .rdata_o (p_rdata)
  );

  assign stat_o.at_end = (idx_q >= cnt_sel);
  assign stat_o.last   = (idx_nxt_w >= {1'b0, cnt_sel});
  assign stat_o.match  = (rdata_sel == key_q);
  assign stat_o.v_full = (32'(v_cnt_q) >= VolatileDepth);
  assign stat_o.p_full = (32'(p_cnt_q) >= PersistentDepth);

  assign v_used_x          = 32'(v_cnt_q);
  assign p_used_x          = 32'(p_cnt_q);
  assign volatile_used_o   = v_used_x[tpbkt_pkg::UsedW-1:0];
  assign persistent_used_o = p_used_x[tpbkt_pkg::UsedW-1:0];

endmodule

// ----- src/tpbkt_ctrl.sv -----
// ----------------------------------------------------------------------------
// tpbkt_ctrl
// Sequencer: find, drop and append steps per operation, result status.
// ----------------------------------------------------------------------------
module tpbkt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  tpbkt_pkg::op_e        op_i,
  input  logic                  sel_i,
  input  tpbkt_pkg::dp_stat_t   stat_i,
  output tpbkt_pkg::dp_cmd_t    cmd_o,
  output logic                  busy_o,
  output logic                  valid_o,
  output tpbkt_pkg::status_e    status_o,
  output logic                  blocked_o
);

  tpbkt_pkg::ctrl_state_e state_q, state_d;
  tpbkt_pkg::op_e         op_q;
  logic                   sel_q;
  tpbkt_pkg::status_e     status_q, status_d;
  logic                   blocked_q, blocked_d;
  logic                   accept;

  assign accept = start_i && (state_q == tpbkt_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tpbkt_pkg::S_IDLE;
      op_q      <= tpbkt_pkg::OP_ADD;
      sel_q     <= 1'b0;
      status_q  <= tpbkt_pkg::ST_OK;
      blocked_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      status_q  <= status_d;
      blocked_q <= blocked_d;
      if (accept) begin
        op_q  <= op_i;
        sel_q <= sel_i;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    blocked_d = blocked_q;
    cmd_o     = '0;

    unique case (state_q)
      tpbkt_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.key_load = 1'b1;
          status_d       = tpbkt_pkg::ST_OK;
          blocked_d      = 1'b0;
          if (op_i == tpbkt_pkg::OP_CLEAR) begin
            cmd_o.clear = 1'b1;
            state_d     = tpbkt_pkg::S_DONE;
          end else if (op_i == tpbkt_pkg::OP_ADD && !sel_i && stat_i.v_full) begin
            status_d = tpbkt_pkg::ST_FULL;
            state_d  = tpbkt_pkg::S_DONE;
          end else begin
            cmd_o.idx_clr = 1'b1;
            state_d       = tpbkt_pkg::S_FV_RD;
          end
        end
      end

      tpbkt_pkg::S_FV_RD: begin
        cmd_o.pool = 1'b0;
        if (!stat_i.at_end) begin
          cmd_o.rd_en = 1'b1;
          state_d     = tpbkt_pkg::S_FV_CMP;
        end else if (op_q == tpbkt_pkg::OP_ADD && sel_q) begin
          // not in volatile pool: check room in persistent pool
          if (stat_i.p_full) begin
            status_d = tpbkt_pkg::ST_FULL;
            state_d  = tpbkt_pkg::S_DONE;
          end else begin
            cmd_o.idx_clr = 1'b1;
            state_d       = tpbkt_pkg::S_FP_RD;
          end
        end else begin
          cmd_o.idx_clr = 1'b1;
          state_d       = tpbkt_pkg::S_FP_RD;
        end
      end

      tpbkt_pkg::S_FV_CMP: begin
        cmd_o.pool = 1'b0;
        if (!stat_i.match) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = tpbkt_pkg::S_FV_RD;
        end else begin
          unique case (op_q)
            tpbkt_pkg::OP_ADD: begin
              if (sel_q) begin
                state_d = tpbkt_pkg::S_DV_RD;
              end else begin
                status_d = tpbkt_pkg::ST_ALREADY;
                state_d  = tpbkt_pkg::S_DONE;
              end
            end
            tpbkt_pkg::OP_REMOVE: state_d = tpbkt_pkg::S_DV_RD;
            tpbkt_pkg::OP_QUERY: begin
              blocked_d = 1'b1;
              state_d   = tpbkt_pkg::S_DONE;
            end
            default: state_d = tpbkt_pkg::S_DONE;
          endcase
        end
      end

      tpbkt_pkg::S_FP_RD: begin
        cmd_o.pool = 1'b1;
        if (!stat_i.at_end) begin
          cmd_o.rd_en = 1'b1;
          state_d     = tpbkt_pkg::S_FP_CMP;
        end else begin
          unique case (op_q)
            tpbkt_pkg::OP_ADD:
              state_d = sel_q ? tpbkt_pkg::S_APP_P : tpbkt_pkg::S_APP_V;
            tpbkt_pkg::OP_REMOVE: begin
              status_d = tpbkt_pkg::ST_NOT_FOUND;
              state_d  = tpbkt_pkg::S_DONE;
            end
            default: state_d = tpbkt_pkg::S_DONE;
          endcase
        end
      end

      tpbkt_pkg::S_FP_CMP: begin
        cmd_o.pool = 1'b1;
        if (!stat_i.match) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = tpbkt_pkg::S_FP_RD;
        end else begin
          unique case (op_q)
            tpbkt_pkg::OP_ADD: begin
              if (sel_q) begin
                status_d = tpbkt_pkg::ST_ALREADY;
                state_d  = tpbkt_pkg::S_DONE;
              end else begin
                state_d = tpbkt_pkg::S_DP_RD;
              end
            end
            tpbkt_pkg::OP_REMOVE: state_d = tpbkt_pkg::S_DP_RD;
            tpbkt_pkg::OP_QUERY: begin
              blocked_d = 1'b1;
              state_d   = tpbkt_pkg::S_DONE;
            end
            default: state_d = tpbkt_pkg::S_DONE;
          endcase
        end
      end

      tpbkt_pkg::S_DV_RD: begin
        cmd_o.pool = 1'b0;
        if (!stat_i.last) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_next = 1'b1;
          state_d       = tpbkt_pkg::S_DV_WR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          if (op_q == tpbkt_pkg::OP_ADD) begin
            if (stat_i.p_full) begin
              status_d = tpbkt_pkg::ST_FULL;
              state_d  = tpbkt_pkg::S_DONE;
            end else begin
              cmd_o.idx_clr = 1'b1;
              state_d       = tpbkt_pkg::S_FP_RD;
            end
          end else begin
            state_d = tpbkt_pkg::S_DONE;
          end
        end
      end

      tpbkt_pkg::S_DV_WR: begin
        // shift the next entry down one slot
        cmd_o.pool    = 1'b0;
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d       = tpbkt_pkg::S_DV_RD;
      end

      tpbkt_pkg::S_DP_RD: begin
        cmd_o.pool = 1'b1;
        if (!stat_i.last) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_next = 1'b1;
          state_d       = tpbkt_pkg::S_DP_WR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d = (op_q == tpbkt_pkg::OP_ADD) ? tpbkt_pkg::S_APP_V : tpbkt_pkg::S_DONE;
        end
      end

      tpbkt_pkg::S_DP_WR: begin
        cmd_o.pool    = 1'b1;
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d       = tpbkt_pkg::S_DP_RD;
      end

      tpbkt_pkg::S_APP_V: begin
        cmd_o.pool   = 1'b0;
        cmd_o.app_en = 1'b1;
        state_d      = tpbkt_pkg::S_DONE;
      end

      tpbkt_pkg::S_APP_P: begin
        cmd_o.pool   = 1'b1;
        cmd_o.app_en = 1'b1;
        state_d      = tpbkt_pkg::S_DONE;
      end

      tpbkt_pkg::S_DONE: begin
        state_d = tpbkt_pkg::S_IDLE;
      end

      default: state_d = tpbkt_pkg::S_IDLE;
    endcase
  end

  assign busy_o    = (state_q != tpbkt_pkg::S_IDLE);
  assign valid_o   = (state_q == tpbkt_pkg::S_DONE);
  assign status_o  = status_q;
  assign blocked_o = blocked_q;

endmodule

// ----- src/two_pool_blocked_keyword_table_top.sv -----
// ----------------------------------------------------------------------------
// two_pool_blocked_keyword_table_top
// Blocked keyword table with a volatile and a persistent ordered pool.
// ----------------------------------------------------------------------------
// One command beat is taken when start is high and busy is low; its result
// shows on the result ports for exactly one cycle with valid_o high, and the
// receiver cannot stall it. Each pool is a RAM with registered read, scanned
// one entry at a time through a read state and a compare state; removal closes
// the gap by moving each later entry down one slot through a read state and a
// write state. A clear, or an add to a full volatile pool, goes straight to
// the result, and busy stays high until the result cycle has passed. No
// clearing pass is needed after reset.
module two_pool_blocked_keyword_table_top #(
  parameter int unsigned VOLATILE_DEPTH   = tpbkt_pkg::VolatileDepthDef,
  parameter int unsigned PERSISTENT_DEPTH = tpbkt_pkg::PersistentDepthDef,
  parameter int unsigned ID_WIDTH         = tpbkt_pkg::IdWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation_i,
  input  logic [tpbkt_pkg::KeywordW-1:0] keyword_id_i,
  input  logic                          pool_select_i,
  output logic                          valid_o,
  output logic [1:0]                    status_o,
  output logic                          is_blocked_o,
  output logic [tpbkt_pkg::UsedW-1:0]   volatile_used_o,
  output logic [tpbkt_pkg::UsedW-1:0]   persistent_used_o
);

  tpbkt_pkg::dp_cmd_t  cmd;
  tpbkt_pkg::dp_stat_t stat;
  tpbkt_pkg::status_e  status;

  tpbkt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .op_i      (tpbkt_pkg::op_e'(operation_i)),
    .sel_i     (pool_select_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy_o    (busy),
    .valid_o   (valid_o),
    .status_o  (status),
    .blocked_o (is_blocked_o)
  );

  tpbkt_datapath #(
    .VolatileDepth   (VOLATILE_DEPTH),
    .PersistentDepth (PERSISTENT_DEPTH),
    .IdWidth         (ID_WIDTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .keyword_i         (keyword_id_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .volatile_used_o   (volatile_used_o),
    .persistent_used_o (persistent_used_o)
  );

  assign status_o = status;

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy)
    else $error("result strobe outside a command");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_blocked_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && is_blocked_o) |-> (status_o == tpbkt_pkg::ST_OK))
    else $error("blocked flag with non-ok status");

endmodule
